>>> sv/integer_set_table_defines.svh
`ifndef INTEGER_SET_TABLE_DEFINES_SVH
`define INTEGER_SET_TABLE_DEFINES_SVH

// Concurrent check on the rising clock edge, disabled while reset is asserted.
`define IST_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("integer_set_table check failed");

// Same check with a caller-supplied message.
`define IST_ASSERT_MSG(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`endif

>>> sv/ist_pkg.sv
`default_nettype none
package ist_pkg;

	localparam int IST_DEPTH = 64;
	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		CMD_ADD   = 3'd0,
		CMD_DEL   = 3'd1,
		CMD_FIND  = 3'd2,
		CMD_NBR   = 3'd3,
		CMD_SORT  = 3'd4,
		CMD_CLEAR = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DONE
	} fsm_t;

endpackage
`default_nettype wire

>>> sv/ist_cell.sv
`default_nettype none
module ist_cell (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic [ist_pkg::DATA_W-1:0] d,
	output logic      [ist_pkg::DATA_W-1:0] q
);
	import ist_pkg::*;

	logic [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= d;
		end
	end

	assign q = data_q;
endmodule
`default_nettype wire

>>> sv/ist_ctrl.sv
`default_nettype none
module ist_ctrl #(
	parameter int DEPTH = ist_pkg::IST_DEPTH
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [2:0]                 cmd,
	input  wire logic [31:0]                value,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [1:0]                      status,
	output logic [5:0]                      found_index,
	output logic                            exact_match,
	output logic [31:0]                     pred_value,
	output logic                            lower_found,
	output logic [31:0]                     succ_value,
	output logic                            higher_found,
	output logic [6:0]                      entry_count,
	output logic [31:0]                     last_entry,
	output logic                            is_empty,
	input  wire logic [ist_pkg::DATA_W-1:0] head,
	input  wire logic [ist_pkg::DATA_W-1:0] next,
	output logic                            shift_en,
	output logic [ist_pkg::DATA_W-1:0]      head_d,
	output logic [ist_pkg::DATA_W-1:0]      tail_d
);
	import ist_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] P_LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] C_FULL = CW'(DEPTH);

	fsm_t state_q, state_n;
	cmd_t cmd_q;
	logic [DATA_W-1:0] val_q;
	logic [AW-1:0] p_q, pass_q, pos_q, pos_n;
	logic [CW-1:0] count_q, count_n;
	logic found_q, found_n, stop_q, stop_n, exact_q, exact_n;
	logic [DATA_W-1:0] lower_q, lower_n, higher_q, higher_n, t0_q, t0_n, tm_q, tm_n;
	logic inr, hit, last_step, sort_more, finish, accept;
	logic [CW:0] p_ext, c_ext;

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_n = S_RUN;
			S_RUN: if (finish) state_n = S_DONE;
			S_DONE: if (out_ready) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		out_valid = 1'b0;
		shift_en = 1'b0;
		case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_RUN: shift_en = 1'b1;
			S_DONE: out_valid = 1'b1;
			default: ;
		endcase
	end

	assign accept = in_valid && in_ready;
	assign p_ext = (CW + 1)'(p_q);
	assign c_ext = (CW + 1)'(count_q);
	assign inr = p_ext < c_ext;
	assign hit = inr && (head == val_q);
	assign last_step = (p_q == P_LAST);
	assign sort_more = (cmd_q == CMD_SORT) && (pass_q != P_LAST);
	assign finish = shift_en && last_step && !sort_more;

	always_comb begin
		tail_d = head;
		head_d = next;
		found_n = found_q;
		pos_n = pos_q;
		stop_n = stop_q;
		exact_n = exact_q;
		lower_n = lower_q;
		higher_n = higher_q;
		case (cmd_q)
			CMD_ADD: begin
				if ((p_ext == c_ext) && (count_q < C_FULL)) begin
					tail_d = val_q;
				end
			end
			CMD_DEL: begin
				if (found_q) begin
					tail_d = next;
				end else if (hit) begin
					tail_d = next;
					found_n = 1'b1;
					pos_n = p_q;
				end
			end
			CMD_FIND: begin
				if (!found_q && hit) begin
					found_n = 1'b1;
					pos_n = p_q;
				end
			end
			CMD_NBR: begin
				if (inr && !stop_q) begin
					if (head < val_q) begin
						lower_n = head;
					end else if (head > val_q) begin
						higher_n = head;
						stop_n = 1'b1;
					end else begin
						exact_n = 1'b1;
					end
				end
			end
			CMD_SORT: begin
				if ((p_ext + 1'b1 < c_ext) && (head > next)) begin
					tail_d = next;
					head_d = head;
				end
			end
			default: ;
		endcase
		t0_n = (p_ext + 1'b1 == c_ext) ? tail_d : t0_q;
		tm_n = (p_ext + 2'd2 == c_ext) ? tail_d : tm_q;
	end

	always_comb begin
		count_n = count_q;
		case (cmd_q)
			CMD_ADD: if (count_q < C_FULL) count_n = count_q + 1'b1;
			CMD_DEL: if (found_n) count_n = count_q - 1'b1;
			CMD_CLEAR: count_n = '0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_n;
			if (finish) begin
				count_q <= count_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_t'(cmd);
			val_q <= value;
			p_q <= '0;
			pass_q <= '0;
			pos_q <= '0;
			found_q <= 1'b0;
			stop_q <= 1'b0;
			exact_q <= 1'b0;
			lower_q <= '1;
			higher_q <= '1;
			t0_q <= '0;
			tm_q <= '0;
		end else if (shift_en) begin
			p_q <= last_step ? '0 : p_q + 1'b1;
			if (last_step) begin
				pass_q <= pass_q + 1'b1;
			end
			pos_q <= pos_n;
			found_q <= found_n;
			stop_q <= stop_n;
			exact_q <= exact_n;
			lower_q <= lower_n;
			higher_q <= higher_n;
			t0_q <= t0_n;
			tm_q <= tm_n;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			status <= ST_OK;
			found_index <= '0;
			exact_match <= 1'b0;
			pred_value <= '0;
			lower_found <= 1'b0;
			succ_value <= '0;
			higher_found <= 1'b0;
			case (cmd_q)
				CMD_ADD: if (count_q >= C_FULL) status <= ST_FULL;
				CMD_DEL, CMD_FIND: begin
					if (found_n) begin
						found_index <= 6'(pos_n);
					end else begin
						status <= ST_NOTFOUND;
					end
				end
				CMD_NBR: begin
					exact_match <= exact_n;
					status <= exact_n ? ST_OK : ST_NOTFOUND;
					pred_value <= lower_n;
					lower_found <= (lower_n != '1);
					succ_value <= higher_n;
					higher_found <= (higher_n != '1);
				end
				default: ;
			endcase
			entry_count <= 7'(count_n);
			is_empty <= (count_n == '0);
			if (count_n == '0) begin
				last_entry <= '0;
			end else if (cmd_q == CMD_ADD && count_q < C_FULL) begin
				last_entry <= val_q;
			end else if (cmd_q == CMD_DEL && found_n) begin
				last_entry <= tm_n;
			end else begin
				last_entry <= t0_n;
			end
		end
	end
endmodule
`default_nettype wire

>>> sv/integer_set_table.sv
// Each command makes one pass over the entries except sort, which makes DEPTH passes;
// each pass rotates the entries once.
// One command is in flight at a time: a new command is taken only after the result of
// the last one has been accepted with out_ready, and the result is held until then.
// Reset empties the table (count zero); entry contents are not cleared.
`default_nettype none
module integer_set_table #(
	parameter int DEPTH = ist_pkg::IST_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  cmd,
	input  wire logic [31:0] value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [5:0]       found_index,
	output logic             exact_match,
	output logic [31:0]      pred_value,
	output logic             lower_found,
	output logic [31:0]      succ_value,
	output logic             higher_found,
	output logic [6:0]       entry_count,
	output logic [31:0]      last_entry,
	output logic             is_empty
);
	import ist_pkg::*;

	logic [DATA_W-1:0] cell_q [DEPTH];
	logic [DATA_W-1:0] head_d, tail_d;
	logic shift_en;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] d;
		if (i == 0) begin : g_head
			assign d = head_d;
		end else if (i == DEPTH - 1) begin : g_tail
			assign d = tail_d;
		end else begin : g_mid
			assign d = cell_q[i + 1];
		end
		ist_cell u_cell (
			.clk (clk),
			.en  (shift_en),
			.d   (d),
			.q   (cell_q[i])
		);
	end

	ist_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.found_index  (found_index),
		.exact_match  (exact_match),
		.pred_value   (pred_value),
		.lower_found  (lower_found),
		.succ_value   (succ_value),
		.higher_found (higher_found),
		.entry_count  (entry_count),
		.last_entry   (last_entry),
		.is_empty     (is_empty),
		.head         (cell_q[0]),
		.next         (cell_q[1]),
		.shift_en     (shift_en),
		.head_d       (head_d),
		.tail_d       (tail_d)
	);
endmodule
`default_nettype wire

>>> sv/ist_checker.sv
`default_nettype none
`include "integer_set_table_defines.svh"
module ist_checker #(
	parameter int DEPTH = ist_pkg::IST_DEPTH
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  status,
	input wire logic [31:0] pred_value,
	input wire logic        lower_found,
	input wire logic [6:0]  entry_count,
	input wire logic        is_empty
);
	import ist_pkg::*;

	`IST_ASSERT(a_empty_flag, out_valid |-> (is_empty == (entry_count == 7'd0)))
	`IST_ASSERT(a_out_holds, (out_valid && !out_ready) |=> (out_valid && $stable(status)))
	`IST_ASSERT_MSG(a_one_in_flight, !(in_ready && out_valid), "input taken while result pending")
	`IST_ASSERT(a_full_count, (out_valid && status == ST_FULL) |-> (entry_count == 7'(DEPTH)))
	`IST_ASSERT(a_lower_flag, (out_valid && lower_found) |-> (pred_value != 32'hFFFF_FFFF))
endmodule

bind integer_set_table ist_checker #(.DEPTH(DEPTH)) u_ist_checker (.*);
`default_nettype wire
